### hw/rtl/rgb_2d_convolution_filter_defines.svh
// Assertion macros for the RGB 2D convolution filter.
// Included by the RTL files that carry concurrent checks; depends on nothing.
`ifndef RGB_2D_CONVOLUTION_FILTER_DEFINES_SVH
`define RGB_2D_CONVOLUTION_FILTER_DEFINES_SVH
`ifndef SYNTHESIS
// Check that is switched off while reset is high.
`define CVF_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("convolution filter check failed");
// Check that also holds while reset is high.
`define CVF_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("convolution filter check failed");
`else
`define CVF_ASSERT(label, prop)
`define CVF_ASSERT_ALWAYS(label, prop)
`endif
`endif

### hw/rtl/cvf_pkg.sv
// Shared types, constants and helper functions of the convolution filter.
// Used by every RTL module of the block; depends on nothing.
package cvf_pkg;

   localparam int MAX_WIDTH      = 1024;
   localparam int MAX_KERNEL     = 7;
   localparam int COEF_FRAC_BITS = 8;
   localparam int LINES          = MAX_KERNEL - 1;
   localparam int COL_W          = 10;
   localparam int SUM_W          = 32;
   localparam int IDX_W          = 3;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_KHALF  = 2'd2;

   // Opcodes on the request channel.
   localparam logic OP_COEF  = 1'b0;
   localparam logic OP_PIXEL = 1'b1;

   typedef logic signed [15:0]       coef_type;
   typedef logic [23:0]              pix_type;
   typedef logic signed [SUM_W-1:0]  sum_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MAC,
      ST_RED,
      ST_FIN
   } state_type;

   // Controls handed from the sequencer to one cell.
   typedef struct packed {
      logic             clear;
      logic             mac_en;
      logic             red_en;
      logic [IDX_W-1:0] step;
      logic [IDX_W-1:0] base;
   } cell_ctl_type;

   // Splits a row-major coefficient index into row and column.
   function automatic logic [2*IDX_W-1:0] coef_pos(input logic [5:0] idx);
      logic [IDX_W-1:0] row;
      logic [5:0]       rest;
      row = '0;
      for (int r = 1; r < MAX_KERNEL; r++) begin
         if (idx >= 6'(r * MAX_KERNEL)) begin
            row = IDX_W'(r);
         end
      end
      rest = idx - 6'(row) * 6'(MAX_KERNEL);
      return {row, rest[IDX_W-1:0]};
   endfunction

   // Drops the fraction, clips at zero and at full scale.
   function automatic logic [7:0] chan_sat(input sum_type sum);
      logic [SUM_W-COEF_FRAC_BITS-1:0] q;
      q = sum[SUM_W-1:COEF_FRAC_BITS];
      if (sum <= 0) begin
         return 8'd0;
      end else if (q > (SUM_W-COEF_FRAC_BITS)'(255)) begin
         return 8'd255;
      end
      return q[7:0];
   endfunction

endpackage

### hw/rtl/rgb_2d_convolution_filter.sv
// Channel  | Ports                 | Contents
// request  | req_tvalid/tready     | tuser opcode; tdata index, coefficient, color
// response | rsp_tvalid/tready     | tuser interior; tdata colors, center position
// config   | csr_psel ... csr_pready | width, height, half kernel size
//
// A pixel beat starts with a load step; an interior result then takes seven
// multiply steps along the cell chain and six steps summing down the chain.
// The response sits in an output register; a full register stalls only the
// final step. Reset is synchronous and clears counters, the configuration
// registers, windows, state and the coefficients; the line buffers start
// undefined and are never read unwritten.
`include "rgb_2d_convolution_filter_defines.svh"
module rgb_2d_convolution_filter import cvf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [5:0] coef_index, [21:6] coef_value, [29:22] in_red, [37:30] in_green,
   // [45:38] in_blue, [47:46] zero
   input  logic [47:0] req_tdata,
   // [0] opcode
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] out_red, [15:8] out_green, [23:16] out_blue, [33:24] center_row,
   // [43:34] center_col, [47:44] zero
   output logic [47:0] rsp_tdata,
   // [0] interior
   output logic        rsp_tuser,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] step_ff, step_in;
   logic [10:0]      width_ff, height_ff;
   logic [1:0]       khalf_ff;
   logic [COL_W-1:0] row_ff, col_ff;
   logic [IDX_W-1:0] slot_ff;
   pix_type          pix_ff;
   logic [COL_W-1:0] row_lat_ff, col_lat_ff;
   logic [IDX_W-1:0] slot_lat_ff, base_ff;
   logic [1:0]       h_lat_ff;
   logic             prod_ff, inside_ff;
   logic             rsp_valid_ff;
   logic [47:0]      rsp_data_ff;
   logic             rsp_user_ff;

   logic             req_fire, pix_fire, coef_fire, csr_wr, out_load;
   logic [5:0]       coef_idx;
   logic [2*IDX_W-1:0] pos;
   pix_type          req_pix;
   logic [10:0]      w_eff, h_eff, col_next, row_next;
   logic             produced, full_win;

   pix_type          line_rd [LINES];
   cell_ctl_type     ctl [MAX_KERNEL];
   coef_type         coef_out [MAX_KERNEL];
   coef_type         coef_in  [MAX_KERNEL];
   sum_type          acc_out  [MAX_KERNEL][3];
   sum_type          acc_prev [MAX_KERNEL][3];
   pix_type          shift_pix [MAX_KERNEL];
   logic             shift_en;

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 11'd1024;
         height_ff <= 11'd1024;
         khalf_ff  <= 2'd1;
      end else if (csr_wr) begin
         priority case (csr_paddr[3:2])
            REG_WIDTH:  width_ff  <= csr_pwdata[10:0];
            REG_HEIGHT: height_ff <= csr_pwdata[10:0];
            REG_KHALF:  khalf_ff  <= csr_pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_WIDTH:  csr_prdata = {21'd0, width_ff};
         REG_HEIGHT: csr_prdata = {21'd0, height_ff};
         REG_KHALF:  csr_prdata = {30'd0, khalf_ff};
         default:    csr_prdata = '0;
      endcase
   end

   // Request decode.
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign pix_fire   = req_fire & (req_tuser == OP_PIXEL);
   assign coef_fire  = req_fire & (req_tuser == OP_COEF);
   assign coef_idx   = req_tdata[5:0];
   assign pos        = coef_pos(coef_idx);
   assign req_pix    = req_tdata[45:22];

   // Frame position counters; the slot follows the row modulo the line count.
   assign w_eff    = (width_ff == 11'd0) ? 11'd1 :
                     (width_ff > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : width_ff;
   assign h_eff    = (height_ff == 11'd0) ? 11'd1 :
                     (height_ff > 11'd1024) ? 11'd1024 : height_ff;
   assign col_next = {1'b0, col_ff} + 11'd1;
   assign row_next = {1'b0, row_ff} + 11'd1;
   assign produced = (row_ff >= COL_W'(khalf_ff)) && (col_ff >= COL_W'(khalf_ff));
   assign full_win = (row_ff >= COL_W'({khalf_ff, 1'b0})) &&
                     (col_ff >= COL_W'({khalf_ff, 1'b0}));

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         col_ff  <= '0;
         slot_ff <= '0;
      end else if (pix_fire) begin
         if (col_next >= w_eff) begin
            col_ff <= '0;
            if (row_next >= h_eff) begin
               row_ff  <= '0;
               slot_ff <= '0;
            end else begin
               row_ff  <= row_next[COL_W-1:0];
               slot_ff <= (slot_ff == IDX_W'(LINES - 1)) ? '0 : slot_ff + 1'b1;
            end
         end else begin
            col_ff <= col_next[COL_W-1:0];
            if ({1'b0, row_ff} >= h_eff) begin
               row_ff  <= '0;
               slot_ff <= '0;
            end
         end
      end
   end

   // Pixel beat details held for the rest of its work.
   always_ff @(posedge clock) begin
      if (pix_fire) begin
         pix_ff      <= req_pix;
         row_lat_ff  <= row_ff;
         col_lat_ff  <= col_ff;
         slot_lat_ff <= slot_ff;
         h_lat_ff    <= khalf_ff;
         base_ff     <= IDX_W'(LINES) - IDX_W'({khalf_ff, 1'b0});
         prod_ff     <= produced;
         inside_ff   <= full_win;
      end
   end

   // Line buffers, one per earlier row.
   for (genvar g = 0; g < LINES; g++) begin : g_line
      cvf_line_ram u_line (
         .clock (clock),
         .we    (pix_fire && (slot_ff == IDX_W'(g))),
         .addr  (col_ff),
         .wdata (req_pix),
         .rdata (line_rd[g])
      );
   end

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      out_load = 1'b0;
      shift_en = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (pix_fire) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            shift_en = 1'b1;
            step_in  = '0;
            if (!prod_ff) begin
               state_in = ST_IDLE;
            end else if (!inside_ff) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            if (step_ff == IDX_W'(MAX_KERNEL - 1)) begin
               step_in  = IDX_W'(1);
               state_in = ST_RED;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_RED: begin
            if (step_ff == IDX_W'(MAX_KERNEL - 1)) begin
               step_in  = '0;
               state_in = ST_FIN;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Cell chain: new column feed, coefficient routing and summing links.
   for (genvar a = 0; a < MAX_KERNEL; a++) begin : g_cell
      logic [IDX_W:0] bank_sum;
      logic [IDX_W-1:0] bank;
      logic [IDX_W-1:0] src;

      always_comb begin
         bank_sum = {1'b0, slot_lat_ff} + (IDX_W+1)'(a);
         bank     = (bank_sum >= (IDX_W+1)'(LINES)) ?
                    IDX_W'(bank_sum - (IDX_W+1)'(LINES)) : bank_sum[IDX_W-1:0];
         if (a == MAX_KERNEL - 1) begin
            shift_pix[a] = pix_ff;
         end else if (COL_W'(MAX_KERNEL - 1 - a) <= row_lat_ff) begin
            shift_pix[a] = line_rd[bank];
         end else begin
            shift_pix[a] = '0;
         end
         src = IDX_W'(a) - base_ff;
         coef_in[a] = (IDX_W'(a) >= base_ff) ? coef_out[src] : '0;
         ctl[a].clear  = (state_ff == ST_LOAD);
         ctl[a].mac_en = (state_ff == ST_MAC);
         ctl[a].red_en = (state_ff == ST_RED) && (step_ff == IDX_W'(a));
         ctl[a].step   = step_ff;
         ctl[a].base   = base_ff;
         for (int c = 0; c < 3; c++) begin
            acc_prev[a][c] = (a == 0) ? '0 : acc_out[(a == 0) ? 0 : a-1][c];
         end
      end

      cvf_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .coef_we    (coef_fire && (coef_idx < 6'(MAX_KERNEL * MAX_KERNEL)) &&
                      (pos[2*IDX_W-1:IDX_W] == IDX_W'(a))),
         .coef_col   (pos[IDX_W-1:0]),
         .coef_wdata (req_tdata[21:6]),
         .shift_en   (shift_en),
         .shift_pix  (shift_pix[a]),
         .ctl        (ctl[a]),
         .coef_in    (coef_in[a]),
         .acc_prev   (acc_prev[a]),
         .coef_out   (coef_out[a]),
         .acc_out    (acc_out[a])
      );
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_user_ff <= inside_ff;
         rsp_data_ff <= {4'd0,
                         col_lat_ff - COL_W'(h_lat_ff),
                         row_lat_ff - COL_W'(h_lat_ff),
                         inside_ff ? chan_sat(acc_out[MAX_KERNEL-1][2]) : 8'd0,
                         inside_ff ? chan_sat(acc_out[MAX_KERNEL-1][1]) : 8'd0,
                         inside_ff ? chan_sat(acc_out[MAX_KERNEL-1][0]) : 8'd0};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `CVF_ASSERT(a_busy_not_ready, (state_ff != ST_IDLE) |-> !req_tready)
   `CVF_ASSERT(a_pixel_loads, pix_fire |=> (state_ff == ST_LOAD))
   `CVF_ASSERT(a_border_zero, (rsp_valid_ff && !rsp_user_ff) |-> (rsp_data_ff[23:0] == 24'd0))
   `CVF_ASSERT_ALWAYS(a_step_range, (state_ff == ST_RED) |-> (step_ff != '0))

endmodule

### hw/rtl/cvf_line_ram.sv
// One line buffer: a single-port RAM with registered read, read-first.
// Depends on cvf_pkg for the row length and pixel type.
module cvf_line_ram import cvf_pkg::*; (
   input  logic             clock,
   input  logic             we,
   input  logic [COL_W-1:0] addr,
   input  pix_type          wdata,
   output pix_type          rdata
);

   pix_type mem [MAX_WIDTH];
   pix_type rdata_ff;

   // Old contents come out when the same entry is written.
   always_ff @(posedge clock) begin
      rdata_ff <= mem[addr];
      if (we) begin
         mem[addr] <= wdata;
      end
   end

   assign rdata = rdata_ff;

endmodule

### hw/rtl/cvf_cell.sv
// One window row of the filter: seven pixels, seven coefficients and a
// multiply-accumulate per color. Depends on cvf_pkg.
module cvf_cell import cvf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             coef_we,
   input  logic [IDX_W-1:0] coef_col,
   input  coef_type         coef_wdata,
   input  logic             shift_en,
   input  pix_type          shift_pix,
   input  cell_ctl_type     ctl,
   input  coef_type         coef_in,
   input  sum_type          acc_prev [3],
   output coef_type         coef_out,
   output sum_type          acc_out [3]
);

   coef_type          coef_ff [MAX_KERNEL];
   pix_type           win_ff  [MAX_KERNEL];
   sum_type           acc_ff  [3];
   sum_type           acc_in  [3];
   logic [IDX_W:0]    pix_idx;
   pix_type           pix_sel;
   logic signed [24:0] prod [3];

   // Coefficient row, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_KERNEL; i++) begin
            coef_ff[i] <= '0;
         end
      end else if (coef_we) begin
         coef_ff[coef_col] <= coef_wdata;
      end
   end

   // Window row shifts left; the newest column enters on the right.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_KERNEL; i++) begin
            win_ff[i] <= '0;
         end
      end else if (shift_en) begin
         for (int i = 0; i < MAX_KERNEL - 1; i++) begin
            win_ff[i] <= win_ff[i+1];
         end
         win_ff[MAX_KERNEL-1] <= shift_pix;
      end
   end

   // The coefficient of the current step goes to the cell that needs it.
   assign coef_out = (ctl.step < IDX_W'(MAX_KERNEL)) ? coef_ff[ctl.step] : '0;

   // Pixel column lines up with the coefficient column plus the window base.
   always_comb begin
      pix_idx = {1'b0, ctl.base} + {1'b0, ctl.step};
      pix_sel = (pix_idx < (IDX_W+1)'(MAX_KERNEL)) ? win_ff[pix_idx[IDX_W-1:0]] : '0;
      for (int c = 0; c < 3; c++) begin
         prod[c] = coef_in * $signed({1'b0, pix_sel[8*c +: 8]});
      end
   end

   // Accumulate products, then fold in the neighbor's sum.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         acc_in[c] = acc_ff[c];
         if (ctl.clear) begin
            acc_in[c] = '0;
         end else if (ctl.mac_en) begin
            acc_in[c] = acc_ff[c] + SUM_W'(prod[c]);
         end else if (ctl.red_en) begin
            acc_in[c] = acc_ff[c] + acc_prev[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         acc_ff[c] <= acc_in[c];
      end
   end

   assign acc_out = acc_ff;

endmodule
